// ----- hw/rtl/kpm_pkg.sv -----
// shared constants for the kernel packet mailbox: ops, sizes, status codes, csr word map
package kpm_pkg;

    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 8;
    localparam int WORD_W  = 5;
    localparam int DELAY_W = 5;
    localparam int LIMIT_W = 5;
    localparam int DRAW_VALUES = 2 ** DELAY_W;

    // csr words that hold storage
    localparam int CSR_STORED = 11;
    localparam int CSR_IDX_W  = 4;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNMAPPED  = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_READ_SIDE = 3'd3;
    localparam logic [2:0] ST_ENQ_REFUSED = 3'd4;
    localparam logic [2:0] ST_DEQ_REFUSED = 3'd5;

    localparam logic [WORD_W-1:0] W_ENQ_VALID  = 5'd0;
    localparam logic [WORD_W-1:0] W_ENQ_PC     = 5'd1;
    localparam logic [WORD_W-1:0] W_ENQ_INFO   = 5'd2;
    localparam logic [WORD_W-1:0] W_ENQ_GROUP  = 5'd3;
    localparam logic [WORD_W-1:0] W_DEQ_VALID  = 5'd4;
    localparam logic [WORD_W-1:0] W_DEQ_STATUS = 5'd5;
    localparam logic [WORD_W-1:0] W_DEQ_PC     = 5'd6;
    localparam logic [WORD_W-1:0] W_DEQ_INFO   = 5'd7;
    localparam logic [WORD_W-1:0] W_DEQ_MTVAL  = 5'd10;

    localparam logic CFG_QUEUE_LIMIT  = 1'b0;
    localparam logic CFG_DELAY_ENABLE = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

endpackage

// ----- hw/rtl/kpm_queue_mem.sv -----
// packet queue storage: pc, info pointer and delay memories with registered read
module kpm_queue_mem #(
    parameter int DEPTH = 16,
    parameter int PTR_W = 4
) (
    input  logic                        clk,
    input  logic                        push_en,
    input  logic [PTR_W-1:0]            push_addr,
    input  logic [kpm_pkg::DATA_W-1:0]  push_pc,
    input  logic [kpm_pkg::DATA_W-1:0]  push_info,
    input  logic [kpm_pkg::DELAY_W-1:0] push_delay,
    input  logic                        dly_wr_en,
    input  logic [PTR_W-1:0]            dly_wr_addr,
    input  logic [kpm_pkg::DELAY_W-1:0] dly_wr_data,
    input  logic                        rd_en,
    input  logic [PTR_W-1:0]            rd_addr,
    output logic [kpm_pkg::DATA_W-1:0]  rd_pc,
    output logic [kpm_pkg::DATA_W-1:0]  rd_info,
    output logic [kpm_pkg::DELAY_W-1:0] rd_delay
);
    import kpm_pkg::*;

    logic [DATA_W-1:0]  pc_mem    [DEPTH];
    logic [DATA_W-1:0]  info_mem  [DEPTH];
    logic [DELAY_W-1:0] delay_mem [DEPTH];

    logic [PTR_W-1:0]   dly_addr;
    logic [DELAY_W-1:0] dly_data;

    // enqueue and head writeback never fall in the same cycle
    assign dly_addr = push_en ? push_addr  : dly_wr_addr;
    assign dly_data = push_en ? push_delay : dly_wr_data;

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            pc_mem[push_addr]   <= push_pc;
            info_mem[push_addr] <= push_info;
        end
        if (push_en || dly_wr_en)
        begin
            delay_mem[dly_addr] <= dly_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_pc    <= pc_mem[rd_addr];
            rd_info  <= info_mem[rd_addr];
            rd_delay <= delay_mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/kernel_packet_mailbox_csr.sv -----
// kernel packet mailbox: csr window over a launch packet queue
//
//  channel  | direction | tdata / data                               | tuser
//  s_*      | in        | addr[7:0] size[9:8] wdata[73:10] draw[78:74] | op[1:0]
//  m_*      | out       | read_data[63:0]                            | status[2:0]
//  cfg_*    | in        | cfg_wdata: limit[4:0] or delay enable[0]   | -
//
// a read or write result is registered in the cycle after accept; a tick first
// reads the head entry of the queue memory, a registered read, then registers its result.
// a new word is taken while a result waits, as long as the output register
// frees up in the same cycle; m_tready low holds the result and stalls input.
// reset clears the csr words, pointers and count; queue entries are not cleared.
module kernel_packet_mailbox_csr #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CSR_COUNT   = 11,
    parameter int DELAY_RANGE = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [79:0]                 s_tdata,   // byte_address, access_size, write_data, delay_draw
    input  logic [1:0]                  s_tuser,   // op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [kpm_pkg::DATA_W-1:0]  m_tdata,   // read_data
    output logic [2:0]                  m_tuser,   // status
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [kpm_pkg::LIMIT_W-1:0] cfg_wdata
);
    import kpm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    typedef enum logic { S_IDLE, S_TICK } state_t;

    state_t             state_reg, state_next;
    logic [DATA_W-1:0]  csr_reg  [CSR_STORED];
    logic [DATA_W-1:0]  csr_next [CSR_STORED];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               dly_en_reg;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic [2:0]         out_status_reg, out_status_next;

    logic [ADDR_W-1:0]  in_addr;
    logic [1:0]         in_size;
    logic [DATA_W-1:0]  in_wdata;
    logic [DELAY_W-1:0] in_draw;
    logic [WORD_W-1:0]  word;
    logic [CSR_IDX_W-1:0] word_idx;
    logic               in_acc;
    logic [DATA_W-1:0]  csr_rd;

    logic               push_en;
    logic [DELAY_W-1:0] push_delay;
    logic               dly_wr_en;
    logic [DELAY_W-1:0] dly_wr_data;
    logic               rd_en;
    logic [DATA_W-1:0]  rd_pc;
    logic [DATA_W-1:0]  rd_info;
    logic [DELAY_W-1:0] rd_delay;

    logic [DELAY_W-1:0] draw_mod [DRAW_VALUES];

    // draw modulo the delay range, worked out at elaboration
    for (genvar g = 0; g < DRAW_VALUES; g++)
    begin : g_draw_mod
        assign draw_mod[g] = DELAY_W'(g % DELAY_RANGE);
    end

    assign in_addr  = s_tdata[7:0];
    assign in_size  = s_tdata[9:8];
    assign in_wdata = s_tdata[73:10];
    assign in_draw  = s_tdata[78:74];
    assign word     = in_addr[7:3];
    assign word_idx = word[CSR_IDX_W-1:0];

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // words past the stored ones read as zero
    assign csr_rd     = (word < WORD_W'(CSR_STORED)) ? csr_reg[word_idx] : '0;
    assign push_delay = dly_en_reg ? draw_mod[in_draw] : '0;
    assign dly_wr_data = rd_delay - 1'b1;

    kpm_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W)
    ) u_queue (
        .clk         (clk),
        .push_en     (push_en),
        .push_addr   (tail_reg),
        .push_pc     (csr_reg[W_ENQ_PC[CSR_IDX_W-1:0]]),
        .push_info   (csr_reg[W_ENQ_INFO[CSR_IDX_W-1:0]]),
        .push_delay  (push_delay),
        .dly_wr_en   (dly_wr_en),
        .dly_wr_addr (head_reg),
        .dly_wr_data (dly_wr_data),
        .rd_en       (rd_en),
        .rd_addr     (head_reg),
        .rd_pc       (rd_pc),
        .rd_info     (rd_info),
        .rd_delay    (rd_delay)
    );

    always_comb
    begin
        state_next      = state_reg;
        csr_next        = csr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        push_en         = 1'b0;
        dly_wr_en       = 1'b0;
        rd_en           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    out_data_next   = '0;
                    out_status_next = ST_OK;
                    if (s_tuser == OP_TICK)
                    begin
                        rd_en      = 1'b1;
                        state_next = S_TICK;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (s_tuser != OP_READ && s_tuser != OP_WRITE)
                        begin
                            out_status_next = ST_UNMAPPED;
                        end
                        else if ({1'b0, word} >= (WORD_W + 1)'(CSR_COUNT))
                        begin
                            out_status_next = ST_UNMAPPED;
                        end
                        else if (s_tuser == OP_READ)
                        begin
                            if (in_size == SIZE_BYTE)
                            begin
                                out_data_next = DATA_W'(csr_rd[{in_addr[2:0], 3'b000} +: 8]);
                            end
                            else if (in_size == SIZE_WORD)
                            begin
                                out_data_next = csr_rd;
                            end
                            else
                            begin
                                out_status_next = ST_BAD_SIZE;
                            end
                        end
                        else if (word == W_ENQ_VALID)
                        begin
                            if (csr_reg[W_ENQ_VALID[CSR_IDX_W-1:0]] != '0
                                || count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                out_status_next = ST_ENQ_REFUSED;
                            end
                            else
                            begin
                                push_en    = 1'b1;
                                tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : tail_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else if (word == W_DEQ_VALID)
                        begin
                            if (csr_reg[W_DEQ_VALID[CSR_IDX_W-1:0]] != DATA_W'(1)
                                || count_reg == '0)
                            begin
                                out_status_next = ST_DEQ_REFUSED;
                            end
                            else
                            begin
                                head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else if (word >= W_ENQ_PC && word <= W_ENQ_GROUP)
                        begin
                            csr_next[word_idx] = in_wdata;
                        end
                        else if (word >= W_DEQ_STATUS && word <= W_DEQ_MTVAL)
                        begin
                            csr_next[word_idx] = in_wdata;
                            out_status_next    = ST_READ_SIDE;
                        end
                    end
                end
            end
            S_TICK:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                if (count_reg == '0)
                begin
                    csr_next[W_ENQ_VALID[CSR_IDX_W-1:0]] = '0;
                    csr_next[W_DEQ_VALID[CSR_IDX_W-1:0]] = '0;
                end
                else
                begin
                    csr_next[W_ENQ_VALID[CSR_IDX_W-1:0]] =
                        DATA_W'(CMP_W'(count_reg) == CMP_W'(limit_reg));
                    csr_next[W_DEQ_PC[CSR_IDX_W-1:0]]   = rd_pc;
                    csr_next[W_DEQ_INFO[CSR_IDX_W-1:0]] = rd_info;
                    if (rd_delay == '0)
                    begin
                        csr_next[W_DEQ_VALID[CSR_IDX_W-1:0]] = DATA_W'(1);
                    end
                    else
                    begin
                        // count the head delay down in place
                        dly_wr_en = 1'b1;
                        csr_next[W_DEQ_VALID[CSR_IDX_W-1:0]] = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            for (int i = 0; i < CSR_STORED; i++)
            begin
                csr_reg[i] <= '0;
            end
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            limit_reg      <= LIMIT_RESET;
            dly_en_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            csr_reg        <= csr_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            if (cfg_we)
            begin
                if (cfg_addr == CFG_QUEUE_LIMIT)
                begin
                    limit_reg <= cfg_wdata;
                end
                else
                begin
                    dly_en_reg <= cfg_wdata[0];
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with head and tail apart");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TICK |=> out_valid_reg)
        else $error("tick gave no result");

    a_tick_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TICK |-> !push_en && !in_acc)
        else $error("input taken during head update");

endmodule
